@@ sv/tap_pkg.sv @@
// shared widths, pipeline stage types and the square root step
package tap_pkg;

  localparam int COORD_W = 16;
  localparam int FRAC_W  = 8;
  localparam int PERIM_W = 27;
  localparam int AREA_W  = 33;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int RAD_W   = SQ_W + 2 * FRAC_W;
  localparam int ROOT_W  = (RAD_W + 1) / 2;
  localparam int PAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CROSS_W = PROD_W + 1;

  typedef struct packed {
    logic [PAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } side_t;

  typedef struct packed {
    side_t [2:0]       side;
    logic              is_tri;
    logic [AREA_W-1:0] area;
  } root_stage_t;

  // one digit of the restoring square root
  function automatic side_t sqrt_step(side_t s);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] test;
    logic             ge;
    side_t            o;
    cur    = {s.rem[REM_W-3:0], s.rad[PAD_W-1 -: 2]};
    test   = {s.root, 2'b01};
    ge     = (cur >= test);
    o.rad  = {s.rad[PAD_W-3:0], 2'b00};
    o.rem  = ge ? (cur - test) : cur;
    o.root = {s.root[ROOT_W-2:0], ge};
    return o;
  endfunction

endpackage

@@ sv/triangle_area_perimeter.sv @@
// triangle validity, perimeter and area from three fixed-point points
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | three vertices, signed q8.8
//  out_    | output    | out_valid/stall  | is_triangle, perimeter, area
//
// the pipe runs differences, products, sums, then one square root
// digit per stage over 25 stages for all three sides, then the final sum
// one transfer per cycle sustained while the output is not stalled; every stage holds one item
// the whole pipe moves together when the output register is empty or taken
// in_stall is high only while a result sits in the output and out_stall holds
// rst_n synchronously clears the valid bits only
module triangle_area_perimeter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tap_pkg::COORD_W-1:0]  in_point_a_x,
  input  logic signed [tap_pkg::COORD_W-1:0]  in_point_a_y,
  input  logic signed [tap_pkg::COORD_W-1:0]  in_point_b_x,
  input  logic signed [tap_pkg::COORD_W-1:0]  in_point_b_y,
  input  logic signed [tap_pkg::COORD_W-1:0]  in_point_c_x,
  input  logic signed [tap_pkg::COORD_W-1:0]  in_point_c_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_triangle,
  output logic [tap_pkg::PERIM_W-1:0]         out_perimeter,
  output logic [tap_pkg::AREA_W-1:0]          out_area
);

  localparam int DW = tap_pkg::DIFF_W;
  localparam int PW = tap_pkg::PROD_W;
  localparam int NR = tap_pkg::ROOT_W;

  logic advance;

  // stage 1: edge vectors ab, ac, bc
  logic                 v1_r;
  logic signed [DW-1:0] abx_r, aby_r, acx_r, acy_r, bcx_r, bcy_r;

  // stage 2: squares and cross terms
  logic                         v2_r;
  logic signed [PW-1:0]         sq_r [6];
  logic signed [PW-1:0]         p1_r, p2_r;

  // stage 3 onward: square root pipe, index 0 is freshly loaded
  logic                         vr_r [NR+1];
  tap_pkg::root_stage_t         rs_r [NR+1];
  tap_pkg::root_stage_t         rs_nxt;

  logic                         out_valid_r;
  logic                         out_tri_r;
  logic [tap_pkg::PERIM_W-1:0]  out_perim_r;
  logic [tap_pkg::AREA_W-1:0]   out_area_r;

  logic signed [tap_pkg::CROSS_W-1:0] cross_val;
  logic [tap_pkg::CROSS_W-1:0]        cross_abs;
  logic [tap_pkg::SQ_W-1:0]           d2 [3];
  logic [tap_pkg::PERIM_W-1:0]        perim_sum;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    cross_val = tap_pkg::CROSS_W'(p1_r) - tap_pkg::CROSS_W'(p2_r);
    cross_abs = cross_val[tap_pkg::CROSS_W-1] ? tap_pkg::CROSS_W'(-cross_val)
                                              : tap_pkg::CROSS_W'(cross_val);
    d2[0] = tap_pkg::SQ_W'(sq_r[0]) + tap_pkg::SQ_W'(sq_r[1]);
    d2[1] = tap_pkg::SQ_W'(sq_r[2]) + tap_pkg::SQ_W'(sq_r[3]);
    d2[2] = tap_pkg::SQ_W'(sq_r[4]) + tap_pkg::SQ_W'(sq_r[5]);
    for (int i = 0; i < 3; i++) begin
      rs_nxt.side[i].rad  = tap_pkg::PAD_W'({d2[i], {(2*tap_pkg::FRAC_W){1'b0}}});
      rs_nxt.side[i].rem  = '0;
      rs_nxt.side[i].root = '0;
    end
    rs_nxt.is_tri = (cross_val != '0);
    rs_nxt.area   = cross_abs[tap_pkg::AREA_W-1:0];
    perim_sum = tap_pkg::PERIM_W'(rs_r[NR].side[0].root)
              + tap_pkg::PERIM_W'(rs_r[NR].side[1].root)
              + tap_pkg::PERIM_W'(rs_r[NR].side[2].root);
  end

  // front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      vr_r[0]  <= 1'b0;
    end else if (advance) begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      vr_r[0]  <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      abx_r   <= DW'(in_point_b_x) - DW'(in_point_a_x);
      aby_r   <= DW'(in_point_b_y) - DW'(in_point_a_y);
      acx_r   <= DW'(in_point_c_x) - DW'(in_point_a_x);
      acy_r   <= DW'(in_point_c_y) - DW'(in_point_a_y);
      bcx_r   <= DW'(in_point_c_x) - DW'(in_point_b_x);
      bcy_r   <= DW'(in_point_c_y) - DW'(in_point_b_y);
      sq_r[0] <= PW'(abx_r) * PW'(abx_r);
      sq_r[1] <= PW'(aby_r) * PW'(aby_r);
      sq_r[2] <= PW'(bcx_r) * PW'(bcx_r);
      sq_r[3] <= PW'(bcy_r) * PW'(bcy_r);
      sq_r[4] <= PW'(acx_r) * PW'(acx_r);
      sq_r[5] <= PW'(acy_r) * PW'(acy_r);
      p1_r    <= PW'(abx_r) * PW'(acy_r);
      p2_r    <= PW'(aby_r) * PW'(acx_r);
      rs_r[0] <= rs_nxt;
    end
  end

  // one root digit per stage
  for (genvar k = 1; k <= NR; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vr_r[k] <= 1'b0;
      end else if (advance) begin
        vr_r[k] <= vr_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        rs_r[k].side[0] <= tap_pkg::sqrt_step(rs_r[k-1].side[0]);
        rs_r[k].side[1] <= tap_pkg::sqrt_step(rs_r[k-1].side[1]);
        rs_r[k].side[2] <= tap_pkg::sqrt_step(rs_r[k-1].side[2]);
        rs_r[k].is_tri  <= rs_r[k-1].is_tri;
        rs_r[k].area    <= rs_r[k-1].area;
      end
    end
  end

  // output register, invalid triangles report zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vr_r[NR];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tri_r   <= rs_r[NR].is_tri;
      out_perim_r <= rs_r[NR].is_tri ? perim_sum : '0;
      out_area_r  <= rs_r[NR].is_tri ? rs_r[NR].area : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_triangle = out_tri_r;
  assign out_perimeter   = out_perim_r;
  assign out_area        = out_area_r;

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_triangle |-> out_perimeter == '0 && out_area == '0)
    else $error("degenerate result not zero");

  a_triangle_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_triangle |-> out_area != '0)
    else $error("valid triangle with zero area");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vr_r[NR]) && $stable(v1_r))
    else $error("pipeline moved during stall");

endmodule
